@@ rtl/f0pm_pkg.sv @@
`timescale 1ns / 1ps
package f0pm_pkg;

   // default parameter values
   localparam int MAX_MARKS_DEF = 16;
   localparam int TIME_BITS_DEF = 32;

   // register indexes
   localparam logic [1:0] CSR_PITCH_LIMIT    = 2'd0;
   localparam logic [1:0] CSR_DEFAULT_PERIOD = 2'd1;
   localparam logic [1:0] CSR_TAIL_END_TIME  = 2'd2;

   // register reset values
   localparam logic [15:0] PITCH_LIMIT_RST    = 16'd32000;
   localparam logic [31:0] DEFAULT_PERIOD_RST = 32'd655;
   localparam logic [31:0] TAIL_END_TIME_RST  = 32'd0;

   // phase accumulator: fractional phase in Q0.24, starts at one half
   localparam int          FRAC_BITS  = 24;
   localparam logic [23:0] PHASE_HALF = 24'h800000;

   // input command codes
   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_TAIL  = 1'b1;

   // handshake between the sequencer and a serial arithmetic unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

@@ rtl/f0_contour_to_pitchmarks_top.sv @@
`timescale 1ns / 1ps
// channel   direction  fields                                   handshake
// req       in         command, frame_time, pitch_value         req_valid / req_ready
// rsp       out        mark_time, last_of_run, overflow         rsp_valid / rsp_ready
// csr       in         csr_index, csr_wdata                     csr_we, no wait
//
// A frame starts with the phase product on the shared multiplier, then per mark
// runs a shift-add, two restoring divides, a square root and sequencing steps;
// a flat or zero-length interval skips the shift-add and the first divide, and
// a zero denominator skips the second. One transaction is worked on at a time.
// Reset is synchronous; it loads the register reset values and clears the frame history.
// A stalled result holds the sequencer before it pushes the next mark; a new transaction
// is taken while the last result still waits.
module f0_contour_to_pitchmarks_top
   import f0pm_pkg::*;
#(
   parameter int MAX_MARKS_PER_FRAME = MAX_MARKS_DEF,
   parameter int TIME_BITS           = TIME_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_command,
   input  logic [31:0] req_frame_time,
   input  logic [15:0] req_pitch_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_mark_time,
   output logic        rsp_last_of_run,
   output logic        rsp_overflow,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   localparam int TB   = TIME_BITS;
   localparam int WC   = (TB > 32) ? TB : 32;
   localparam int WACC = TB + 18;
   localparam int WP   = WACC + 16;
   localparam int DW   = (TB + 1 > 34) ? TB + 1 : 34;
   localparam int KW   = $clog2(MAX_MARKS_PER_FRAME + 1);
   localparam int WW   = WACC - FRAC_BITS;
   localparam logic [WACC-1:0] ONE_CYCLE = WACC'(1) << FRAC_BITS;

   typedef enum logic [3:0] {
      S_IDLE, S_TAIL, S_ACC_GO, S_ACC_WAIT, S_MARK, S_TMUL_GO, S_TMUL_WAIT,
      S_TDIV_GO, S_TDIV_WAIT, S_SQ_GO, S_SQ_WAIT, S_ODIV_GO, S_ODIV_WAIT, S_PUSH
   } state_type;

   state_type       state_ff, state_in;
   logic [15:0]     limit_ff, limit_in;
   logic [31:0]     dper_ff, dper_in, tend_ff, tend_in;
   logic [TB-1:0]   last_time_ff, last_time_in;
   logic [15:0]     prev_pitch_ff, prev_pitch_in;
   logic [23:0]     phase_ff, phase_in;
   logic            seen_ff, seen_in;
   logic [TB-1:0]   t2_ff, t2_in, span_ff, span_in, mark_ff, mark_in;
   logic [15:0]     f1_ff, f1_in, f2_ff, f2_in;
   logic [WACC-1:0] a_ff, a_in;
   logic [KW-1:0]   n_ff, n_in, k_ff, k_in;
   logic            over_ff, over_in;
   logic [63:0]     term_ff, term_in;
   logic [29:0]     f2sq_ff, f2sq_in;
   logic [32:0]     den_ff, den_in;
   logic            rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic            rsp_over_ff, rsp_over_in;
   logic [31:0]     rsp_time_ff, rsp_time_in;

   // combinational helpers
   logic [TB-1:0]   in_time;
   logic [15:0]     clean_pitch, mag;
   logic [WACC-1:0] acc;
   logic [WW-1:0]   whole;
   logic            acc_over;
   logic [KW-1:0]   acc_n;
   logic [WC:0]     tail_sum;
   logic [63:0]     disc;
   logic [32:0]     den_sum;
   logic            out_free;

   // serial units; the multiplier and the divider are shared
   logic                mul_start, div_start, sq_start;
   logic [WACC-1:0]     mul_a;
   logic [15:0]         mul_b;
   logic [WP-1:0]       mul_prod, div_num, div_quo;
   logic [DW-1:0]       div_den;
   logic [31:0]         sq_root;
   unit_status_type     mul_st, div_st, sq_st;

   assign mul_start = (state_ff == S_ACC_GO) || (state_ff == S_TMUL_GO);
   assign mul_a     = (state_ff == S_ACC_GO) ? WACC'(span_ff) : a_ff;
   assign mul_b     = (state_ff == S_ACC_GO) ? 16'(f1_ff + f2_ff) : mag;
   assign div_start = (state_ff == S_TDIV_GO) || (state_ff == S_ODIV_GO);
   assign div_num   = (state_ff == S_TDIV_GO) ? mul_prod : WP'(a_ff);
   assign div_den   = (state_ff == S_TDIV_GO) ? DW'({span_ff, 1'b0}) : DW'({den_ff, 1'b0});
   assign sq_start  = (state_ff == S_SQ_GO);

   f0pm_mul #(.AW(WACC), .BW(16)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .a(mul_a), .b(mul_b), .prod(mul_prod), .status(mul_st)
   );

   f0pm_div #(.NW(WP), .DW(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(div_den), .quo(div_quo), .status(div_st)
   );

   f0pm_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start),
      .radicand(disc), .root(sq_root), .status(sq_st)
   );

   // datapath helpers
   always_comb begin
      in_time     = TB'(req_frame_time);
      clean_pitch = req_pitch_value[15] ? 16'd0 : req_pitch_value;
      if (clean_pitch > limit_ff) begin
         clean_pitch = prev_pitch_ff;
      end
      mag      = (f2_ff >= f1_ff) ? 16'(f2_ff - f1_ff) : 16'(f1_ff - f2_ff);
      acc      = WACC'(phase_ff) + WACC'({mul_prod[WACC-2:0], 1'b0});
      whole    = acc[WACC-1:FRAC_BITS];
      acc_over = whole > WW'(MAX_MARKS_PER_FRAME);
      acc_n    = acc_over ? KW'(MAX_MARKS_PER_FRAME) : KW'(whole);
      tail_sum = (WC + 1)'(last_time_ff) + (WC + 1)'(dper_ff);
      if (f2_ff > f1_ff) begin
         disc = (term_ff >= 64'(f2sq_ff)) ? 64'd0 : 64'(f2sq_ff) - term_ff;
      end else begin
         disc = 64'(f2sq_ff) + term_ff;
      end
      den_sum  = 33'(f2_ff) + 33'(sq_root);
      out_free = !rsp_valid_ff || rsp_ready;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      limit_in      = limit_ff;
      dper_in       = dper_ff;
      tend_in       = tend_ff;
      last_time_in  = last_time_ff;
      prev_pitch_in = prev_pitch_ff;
      phase_in      = phase_ff;
      seen_in       = seen_ff;
      t2_in         = t2_ff;
      span_in       = span_ff;
      mark_in       = mark_ff;
      f1_in         = f1_ff;
      f2_in         = f2_ff;
      a_in          = a_ff;
      n_in          = n_ff;
      k_in          = k_ff;
      over_in       = over_ff;
      term_in       = term_ff;
      f2sq_in       = f2sq_ff;
      den_in        = den_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_last_in   = rsp_last_ff;
      rsp_over_in   = rsp_over_ff;
      rsp_time_in   = rsp_time_ff;

      // register writes
      if (csr_we) begin
         case (csr_index)
            CSR_PITCH_LIMIT:    limit_in = csr_wdata[15:0];
            CSR_DEFAULT_PERIOD: dper_in  = csr_wdata;
            CSR_TAIL_END_TIME:  tend_in  = csr_wdata;
            default:            ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_TAIL) begin
                  if ((WC'(last_time_ff) < WC'(tend_ff)) &&
                      (last_time_ff != {TB{1'b1}})) begin
                     if (tail_sum > (WC + 1)'({TB{1'b1}})) begin
                        last_time_in = {TB{1'b1}};
                     end else begin
                        last_time_in = TB'(tail_sum);
                     end
                     state_in = S_TAIL;
                  end
               end else begin
                  t2_in    = in_time;
                  f2_in    = clean_pitch;
                  f1_in    = seen_ff ? prev_pitch_ff : clean_pitch;
                  span_in  = (in_time >= last_time_ff) ? TB'(in_time - last_time_ff) : '0;
                  state_in = S_ACC_GO;
               end
            end
         end
         S_TAIL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = 32'(last_time_ff);
               rsp_last_in  = 1'b1;
               rsp_over_in  = 1'b0;
               state_in     = S_IDLE;
            end
         end
         S_ACC_GO: begin
            f2sq_in  = 30'(f2_ff[14:0]) * 30'(f2_ff[14:0]);
            state_in = S_ACC_WAIT;
         end
         S_ACC_WAIT: begin
            if (mul_st.done) begin
               over_in = acc_over;
               n_in    = acc_n;
               k_in    = KW'(1);
               if (acc_n == '0) begin
                  phase_in      = acc[23:0];
                  last_time_in  = t2_ff;
                  prev_pitch_in = f2_ff;
                  seen_in       = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  a_in     = acc - ONE_CYCLE;
                  state_in = S_MARK;
               end
            end
         end
         S_MARK: begin
            if ((span_ff != '0) && (mag != '0)) begin
               state_in = S_TMUL_GO;
            end else begin
               term_in  = '0;
               state_in = S_SQ_GO;
            end
         end
         S_TMUL_GO:   state_in = S_TMUL_WAIT;
         S_TMUL_WAIT: if (mul_st.done) state_in = S_TDIV_GO;
         S_TDIV_GO:   state_in = S_TDIV_WAIT;
         S_TDIV_WAIT: begin
            if (div_st.done) begin
               term_in  = 64'(div_quo);
               state_in = S_SQ_GO;
            end
         end
         S_SQ_GO:     state_in = S_SQ_WAIT;
         S_SQ_WAIT: begin
            if (sq_st.done) begin
               den_in = den_sum;
               if (den_sum == '0) begin
                  mark_in  = t2_ff;
                  state_in = S_PUSH;
               end else begin
                  state_in = S_ODIV_GO;
               end
            end
         end
         S_ODIV_GO:   state_in = S_ODIV_WAIT;
         S_ODIV_WAIT: begin
            if (div_st.done) begin
               mark_in  = (div_quo >= WP'(t2_ff)) ? '0 : TB'(t2_ff - TB'(div_quo));
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_time_in  = 32'(mark_ff);
               rsp_last_in  = (k_ff == n_ff);
               rsp_over_in  = over_ff;
               if (k_ff == n_ff) begin
                  phase_in      = a_ff[23:0];
                  last_time_in  = t2_ff;
                  prev_pitch_in = f2_ff;
                  seen_in       = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  a_in     = a_ff - ONE_CYCLE;
                  k_in     = k_ff + KW'(1);
                  state_in = S_MARK;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         limit_ff      <= PITCH_LIMIT_RST;
         dper_ff       <= DEFAULT_PERIOD_RST;
         tend_ff       <= TAIL_END_TIME_RST;
         last_time_ff  <= '0;
         prev_pitch_ff <= '0;
         phase_ff      <= PHASE_HALF;
         seen_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         limit_ff      <= limit_in;
         dper_ff       <= dper_in;
         tend_ff       <= tend_in;
         last_time_ff  <= last_time_in;
         prev_pitch_ff <= prev_pitch_in;
         phase_ff      <= phase_in;
         seen_ff       <= seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      t2_ff       <= t2_in;
      span_ff     <= span_in;
      mark_ff     <= mark_in;
      f1_ff       <= f1_in;
      f2_ff       <= f2_in;
      a_ff        <= a_in;
      n_ff        <= n_in;
      k_ff        <= k_in;
      over_ff     <= over_in;
      term_ff     <= term_in;
      f2sq_ff     <= f2sq_in;
      den_ff      <= den_in;
      rsp_last_ff <= rsp_last_in;
      rsp_over_ff <= rsp_over_in;
      rsp_time_ff <= rsp_time_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mark_time   = rsp_time_ff;
   assign rsp_last_of_run = rsp_last_ff;
   assign rsp_overflow    = rsp_over_ff;

   // no serial unit runs while a new transaction can be taken
   a_idle_units: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mul_st.busy && !div_st.busy && !sq_st.busy)
      else $error("serial unit busy while idle");

   // mark counter never passes the mark count of the frame
   a_k_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH) |-> (k_ff <= n_ff) && (k_ff != '0))
      else $error("mark counter out of range");

   // an overflowing frame always delivers the full cap
   a_over_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUSH && over_ff) |-> n_ff == KW'(MAX_MARKS_PER_FRAME))
      else $error("overflow frame short of cap");

   // a new result is loaded only from a mark or tail push
   a_load_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == S_PUSH || $past(state_ff) == S_TAIL))
      else $error("result loaded from wrong state");

endmodule

@@ rtl/f0pm_mul.sv @@
`timescale 1ns / 1ps
module f0pm_mul
   import f0pm_pkg::*;
#(
   parameter int AW = 50,
   parameter int BW = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [AW-1:0]        a,
   input  logic [BW-1:0]        b,
   output logic [AW+BW-1:0]     prod,
   output unit_status_type      status
);
   localparam int PW = AW + BW;
   localparam int CW = $clog2(BW + 1);

   logic [PW-1:0] acc_ff, acc_in, sh_ff, sh_in;
   logic [BW-1:0] b_ff, b_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   // shift-add, one multiplier bit per cycle
   always_comb begin
      acc_in  = acc_ff;
      sh_in   = sh_ff;
      b_in    = b_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         sh_in   = PW'(a);
         b_in    = b;
         cnt_in  = CW'(BW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + sh_ff;
         end
         sh_in  = {sh_ff[PW-2:0], 1'b0};
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      sh_ff  <= sh_in;
      b_ff   <= b_in;
      cnt_ff <= cnt_in;
   end

   assign prod        = acc_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ rtl/f0pm_div.sv @@
`timescale 1ns / 1ps
module f0pm_div
   import f0pm_pkg::*;
#(
   parameter int NW = 66,
   parameter int DW = 34
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NW-1:0]   num,
   input  logic [DW-1:0]   den,
   output logic [NW-1:0]   quo,
   output unit_status_type status
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW-1:0] rem_ff, rem_in, d_ff, d_in;
   logic [DW:0]   trial;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   // restoring division, one quotient bit per cycle
   always_comb begin
      q_in    = q_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, q_ff[NW-1]};
      if (start) begin
         q_in    = num;
         rem_in  = '0;
         d_in    = den;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            rem_in = DW'(trial - {1'b0, d_ff});
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = DW'(trial);
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      d_ff   <= d_in;
      cnt_ff <= cnt_in;
   end

   assign quo         = q_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ rtl/f0pm_sqrt.sv @@
`timescale 1ns / 1ps
module f0pm_sqrt
   import f0pm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [63:0]     radicand,
   output logic [31:0]     root,
   output unit_status_type status
);
   logic [63:0] val_ff, val_in;
   logic [33:0] rem_ff, rem_in;
   logic [34:0] rem_sh, trial;
   logic [31:0] root_ff, root_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;

   // digit-by-digit root, two radicand bits per cycle
   always_comb begin
      val_in  = val_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[32:0], val_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start) begin
         val_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 6'd32;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rem_sh >= trial) begin
            rem_in  = 34'(rem_sh - trial);
            root_in = {root_ff[30:0], 1'b1};
         end else begin
            rem_in  = 34'(rem_sh);
            root_in = {root_ff[30:0], 1'b0};
         end
         val_in = {val_ff[61:0], 2'b00};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      val_ff  <= val_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign root        = root_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
   import f0pm_pkg::*;

   typedef struct {
      logic [31:0] mark;
      logic        last;
      logic        ovf;
   } mark_rec_type;

   int error_count = 0;

   task automatic report_mismatch(input string what);
      $display("ERROR %0t: %s", $realtime, what);
      error_count++;
   endtask

   // predicts pitchmarks and keeps the queue of marks still owed by the block
   class mark_scoreboard;
      logic [15:0] lim_r;
      logic [31:0] period_r;
      logic [31:0] tail_end_r;
      logic [63:0] last_time;
      logic [31:0] prev_pitch;
      logic [63:0] phase;
      bit          seen_first;
      mark_rec_type pending[$];

      function new();
         lim_r = PITCH_LIMIT_RST;
         period_r = DEFAULT_PERIOD_RST;
         tail_end_r = TAIL_END_TIME_RST;
         last_time = 0;
         prev_pitch = 0;
         phase = 64'(PHASE_HALF);
         seen_first = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [31:0] val);
         if (idx == CSR_PITCH_LIMIT) lim_r = val[15:0];
         else if (idx == CSR_DEFAULT_PERIOD) period_r = val;
         else if (idx == CSR_TAIL_END_TIME) tail_end_r = val;
      endfunction

      function logic [63:0] int_sqrt(logic [63:0] v);
         logic [63:0] r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      function logic [63:0] mark_at(logic [63:0] t2, logic [63:0] span, logic [31:0] f1,
                                    logic [31:0] f2, logic [63:0] a);
         logic [63:0] f2sq, mag, term, disc, den, offs, d2;
         f2sq = 64'(f2) * 64'(f2);
         mag = (f2 >= f1) ? 64'(f2 - f1) : 64'(f1 - f2);
         term = 0;
         if (span != 0 && mag != 0) begin
            d2 = 2 * span;
            term = (a / d2) * mag + ((a % d2) * mag) / d2;
         end
         if (f2 > f1) disc = (term >= f2sq) ? 0 : f2sq - term;
         else disc = f2sq + term;
         den = 64'(f2) + int_sqrt(disc);
         offs = (den != 0) ? a / (2 * den) : 0;
         return (offs >= t2) ? 0 : t2 - offs;
      endfunction

      // note an accepted input transaction
      function void note_input(logic cmd, logic [31:0] ftime, logic [15:0] pv);
         logic [63:0] t2, span, acc, whole, n, t;
         logic [31:0] f1, f2;
         bit over;
         mark_rec_type rec;
         if (cmd == CMD_TAIL) begin
            if (last_time >= 64'(tail_end_r) || last_time >= 64'hFFFF_FFFF) return;
            t = last_time + 64'(period_r);
            if (t > 64'hFFFF_FFFF) t = 64'hFFFF_FFFF;
            last_time = t;
            rec.mark = t[31:0];
            rec.last = 1;
            rec.ovf = 0;
            pending.push_back(rec);
            return;
         end
         t2 = 64'(ftime);
         f2 = pv[15] ? 32'd0 : 32'(pv);
         if (f2 > 32'(lim_r)) f2 = prev_pitch;
         f1 = seen_first ? prev_pitch : f2;
         span = (t2 >= last_time) ? t2 - last_time : 0;
         acc = phase + 2 * span * 64'(f1 + f2);
         whole = acc >> FRAC_BITS;
         over = whole > MAX_MARKS_DEF;
         n = over ? MAX_MARKS_DEF : whole;
         for (int k = 1; k <= n; k++) begin
            rec.mark = 32'(mark_at(t2, span, f1, f2, acc - (64'(k) << FRAC_BITS)));
            rec.last = (k == n);
            rec.ovf = over;
            pending.push_back(rec);
         end
         phase = acc & ((64'd1 << FRAC_BITS) - 1);
         last_time = t2;
         prev_pitch = f2;
         seen_first = 1;
      endfunction

      // check one accepted result against the oldest expected mark
      task check_result(logic [31:0] m, logic l, logic o);
         mark_rec_type e;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected mark %h", m));
            return;
         end
         e = pending.pop_front();
         if (m !== e.mark)
            report_mismatch($sformatf("mark_time %h, expected %h", m, e.mark));
         if (l !== e.last)
            report_mismatch($sformatf("last_of_run %b, expected %b", l, e.last));
         if (o !== e.ovf)
            report_mismatch($sformatf("overflow %b, expected %b", o, e.ovf));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic        req_command = 0;
   logic [31:0] req_frame_time = 0;
   logic [15:0] req_pitch_value = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [31:0] rsp_mark_time;
   logic        rsp_last_of_run;
   logic        rsp_overflow;
   logic        csr_we = 0;
   logic [1:0]  csr_index = 0;
   logic [31:0] csr_wdata = 0;

   mark_scoreboard marks = new();
   logic [31:0] cur_time = 0;
   int          gap_left = 0;
   int          burst_left = 0;
   bit          stall_free = 0;

   f0_contour_to_pitchmarks_top uut (.*);

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // receiver: stalls at random, with quiet stretches of none
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         marks.check_result(rsp_mark_time, rsp_last_of_run, rsp_overflow);
      if (stall_free) rsp_ready <= 1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] val);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      marks.write_reg(idx, val);
      @(posedge clock);
   endtask

   // send one transaction, with bursty gaps on the sender side
   task automatic send_item(input logic cmd, input logic [31:0] ftime,
                            input logic [15:0] pv);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
         if (gap_left > 0) begin
            req_valid <= 0;
            repeat (gap_left) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1;
      req_command <= cmd;
      req_frame_time <= ftime;
      req_pitch_value <= pv;
      do @(posedge clock); while (!req_ready);
      marks.note_input(cmd, ftime, pv);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (marks.pending.size() != 0) @(posedge clock);
      repeat (4000) @(posedge clock);
   endtask

   // frame advancing time by a small step, now and then stamped a little earlier, pitch mostly in a speech range
   task automatic random_frame();
      logic [15:0] pv;
      int r;
      r = $urandom_range(0, 19);
      cur_time = cur_time + $urandom_range(0, 400);
      if (r == 0) pv = 16'($urandom);
      else if (r == 1) pv = 16'h8000 | 16'($urandom);
      else pv = 16'($urandom_range(3000, 20000));
      if (r == 2) send_item(CMD_FRAME, cur_time - $urandom_range(0, 300), pv);
      else send_item(CMD_FRAME, cur_time, pv);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: first frame, flat, negative, over limit, backwards, extremes
      send_item(CMD_FRAME, 32'd655, 16'd12800);
      send_item(CMD_FRAME, 32'd1310, 16'd16000);
      send_item(CMD_FRAME, 32'd1966, 16'd9000);
      send_item(CMD_FRAME, 32'd2621, 16'hFFFF);
      send_item(CMD_FRAME, 32'd3000, 16'h8000);
      send_item(CMD_FRAME, 32'd3300, 16'd40000 - 16'd40000 + 16'd32767);
      send_item(CMD_FRAME, 32'd3000, 16'd10000);
      send_item(CMD_FRAME, 32'd3000, 16'd10000);
      send_item(CMD_FRAME, 32'd8000, 16'd30000);
      send_item(CMD_FRAME, 32'd8010, 16'd0);
      send_item(CMD_TAIL, 32'd0, 16'd0);
      drain();
      csr_write(CSR_TAIL_END_TIME, 32'd12000);
      csr_write(CSR_DEFAULT_PERIOD, 32'd1500);
      repeat (4) send_item(CMD_TAIL, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(CMD_FRAME, 32'd14000, 16'd5000);
      drain();
      csr_write(CSR_PITCH_LIMIT, 32'h0000_FFFF);
      csr_write(CSR_DEFAULT_PERIOD, 32'hFFFF_FFFF);
      csr_write(CSR_TAIL_END_TIME, 32'hFFFF_FFFF);
      send_item(CMD_FRAME, 32'd15000, 16'd32767);
      send_item(CMD_TAIL, 32'd0, 16'd0);
      send_item(CMD_TAIL, 32'd0, 16'd0);
      send_item(CMD_FRAME, 32'hFFFF_FFFF, 16'd100);
      drain();
      csr_write(CSR_PITCH_LIMIT, 32'd0);
      send_item(CMD_FRAME, 32'h0000_0000, 16'd50);
      drain();

      // random phases across several register settings
      cur_time = 0;
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(CSR_PITCH_LIMIT, (ph == 0) ? 32'd32000 : 32'($urandom_range(8000, 24000)));
         csr_write(CSR_DEFAULT_PERIOD, (ph == 3) ? 32'd0 : $urandom_range(1, 1200));
         csr_write(CSR_TAIL_END_TIME, cur_time + $urandom_range(0, 20000));
         stall_free = (ph == 2);
         for (int i = 0; i < 27; i++) begin
            if ($urandom_range(0, 5) == 0)
               send_item(CMD_TAIL, $urandom, 16'($urandom));
            else
               random_frame();
            cur_time = (marks.last_time[31:0] > cur_time) ? marks.last_time[31:0] : cur_time;
         end
         drain();
      end

      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // overall time limit
   initial begin
      #200ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

@@ f0_contour_to_pitchmarks_top.f @@
rtl/f0pm_pkg.sv
rtl/f0pm_mul.sv
rtl/f0pm_div.sv
rtl/f0pm_sqrt.sv
rtl/f0_contour_to_pitchmarks_top.sv
tb/testbench.sv
